// ===== src/r2fft_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radix-2 FFT block: sizes, data types, states and the twiddle ROM.
// Used by the cell, butterfly and top-level modules; depends on nothing.
package r2fft_pkg;

    localparam int N      = 64;
    localparam int LOG_N  = $clog2(N);
    localparam int AW     = LOG_N;
    localparam int W      = 24;
    localparam int CW     = LOG_N + 2;
    localparam int SW     = 3;
    localparam int LAT    = 3;
    localparam int WB_OFS = LAT + 1;

    typedef logic [AW-1:0] t_addr;

    typedef struct packed {
        logic signed [W-1:0] im;
        logic signed [W-1:0] re;
    } t_cplx;

    typedef struct packed {
        logic shift;
        logic wb;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FILL,
        S_CALC,
        S_ALIGN,
        S_UNLOAD
    } t_state;

    localparam logic signed [15:0] QSINE [17] = '{
        16'sd0, 16'sd3212, 16'sd6393, 16'sd9512, 16'sd12540, 16'sd15447, 16'sd18205,
        16'sd20788, 16'sd23170, 16'sd25330, 16'sd27246, 16'sd28899, 16'sd30274,
        16'sd31357, 16'sd32138, 16'sd32610, 16'sd32767
    };

    function automatic logic signed [15:0] rom_cos(input logic [4:0] k);
        logic [4:0] idx;
        if (k <= 5'd16) begin
            idx = 5'd16 - k;
            return QSINE[idx];
        end
        idx = k - 5'd16;
        return -QSINE[idx];
    endfunction

    function automatic logic signed [15:0] rom_sin(input logic [4:0] k);
        logic [4:0] idx;
        if (k <= 5'd16) begin
            idx = k;
            return QSINE[idx];
        end
        idx = 5'd0 - k;
        return QSINE[idx];
    endfunction

    function automatic t_addr bit_rev(input t_addr a);
        t_addr r;
        for (int b = 0; b < AW; b++) begin
            r[b] = a[AW-1-b];
        end
        return r;
    endfunction

endpackage

// ===== src/r2fft_cell.sv =====
`timescale 1ns / 1ps
// One cell of the rotating sample ring: holds one complex value.
// Depends on r2fft_pkg for the data and control types.
module r2fft_cell (
    input  logic                i_clk,
    input  r2fft_pkg::t_cell_ctl i_ctl,
    input  r2fft_pkg::t_cplx    i_nbr,
    input  r2fft_pkg::t_cplx    i_wb_val,
    output r2fft_pkg::t_cplx    o_val
);
    import r2fft_pkg::*;

    t_cplx r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wb) begin
            r_val <= i_wb_val;
        end else if (i_ctl.shift) begin
            r_val <= i_nbr;
        end
    end

    assign o_val = r_val;

endmodule

// ===== src/r2fft_bfly.sv =====
`timescale 1ns / 1ps
// Three-stage pipelined radix-2 butterfly with twiddle multiply and optional halving.
// Depends on r2fft_pkg for widths and the complex type.
module r2fft_bfly (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_fwd,
    input  r2fft_pkg::t_cplx    i_a,
    input  r2fft_pkg::t_cplx    i_b,
    input  logic signed [15:0]  i_cos,
    input  logic signed [15:0]  i_sin,
    output logic                o_valid,
    output r2fft_pkg::t_cplx    o_x,
    output r2fft_pkg::t_cplx    o_y
);
    import r2fft_pkg::*;

    localparam int PW = W + 16;

    logic [2:0] r_vld;
    t_cplx r_a0, r_b0, r_a1;
    logic signed [15:0] r_c0, r_s0;
    logic signed [PW-1:0] r_prr, r_pii, r_pri, r_pir;
    t_cplx r_x, r_y;

    logic signed [PW:0]  w_tre, w_tim;
    logic signed [W-1:0] w_tr, w_ti;
    logic signed [W:0]   w_sr, w_si, w_dr, w_di;
    t_cplx n_x, n_y;

    function automatic logic signed [W-1:0] fin(input logic signed [W:0] v,
                                                input logic fwd);
        logic signed [W+1:0] h;
        h = ({v[W], v} + (W+2)'(1)) >>> 1;
        return fwd ? h[W-1:0] : v[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0  <= i_a;
        r_b0  <= i_b;
        r_c0  <= i_cos;
        r_s0  <= i_sin;
        r_prr <= PW'(r_c0 * r_b0.re);
        r_pii <= PW'(r_s0 * r_b0.im);
        r_pri <= PW'(r_s0 * r_b0.re);
        r_pir <= PW'(r_c0 * r_b0.im);
        r_a1  <= r_a0;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    always_comb begin
        w_tre = ({r_prr[PW-1], r_prr} - {r_pii[PW-1], r_pii} + (PW+1)'(16384)) >>> 15;
        w_tim = ({r_pri[PW-1], r_pri} + {r_pir[PW-1], r_pir} + (PW+1)'(16384)) >>> 15;
        w_tr  = w_tre[W-1:0];
        w_ti  = w_tim[W-1:0];
        w_sr  = {r_a1.re[W-1], r_a1.re} + {w_tr[W-1], w_tr};
        w_si  = {r_a1.im[W-1], r_a1.im} + {w_ti[W-1], w_ti};
        w_dr  = {r_a1.re[W-1], r_a1.re} - {w_tr[W-1], w_tr};
        w_di  = {r_a1.im[W-1], r_a1.im} - {w_ti[W-1], w_ti};
        n_x.re = fin(w_sr, i_fwd);
        n_x.im = fin(w_si, i_fwd);
        n_y.re = fin(w_dr, i_fwd);
        n_y.im = fin(w_di, i_fwd);
    end

    assign o_valid = r_vld[2];
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// ===== src/radix2_fft.sv =====
`timescale 1ns / 1ps
// Top level of the radix-2 decimation-in-time FFT: sample store, cell ring, sequencer.
// Depends on r2fft_pkg, r2fft_cell and r2fft_bfly.
//
//  Channel   Signals                                      Direction
//  request   i_req_valid, o_req_ready, i_sample_re/im     in
//  bin       o_bin_valid, i_bin_ready, o_bin_re/im, flags out
//  config    i_cfg_we, i_cfg_data                         in
//
// A frame takes N requests, a copy of the store into the ring in bit-reversed
// order, log2(N) stages of butterflies (each issued as its pair passes cell 0,
// with a pipeline drain at the end of each stage), a ring alignment and the
// bin output.
// Reset is synchronous and needs no clearing pass. Output stalls hold the ring.
module radix2_fft (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic signed [15:0] i_sample_re,
    input  logic signed [15:0] i_sample_im,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_bin_valid,
    input  logic        i_bin_ready,
    output logic signed [15:0] o_bin_re,
    output logic signed [15:0] o_bin_im,
    output logic        o_last_bin,
    output logic        o_saturated
);
    import r2fft_pkg::*;

    localparam t_addr WB_A = t_addr'(N - WB_OFS);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_stage, n_stage;
    t_addr r_pos, n_pos;
    t_addr r_load_cnt;
    logic r_forward_mode, r_fwd;
    logic [31:0] r_mem [N];
    logic [31:0] r_rd;
    logic r_ov, r_last, r_sat;
    logic signed [15:0] r_ore, r_oim;

    logic w_accept, w_shift, w_fill, w_take, w_issue;
    t_addr w_m, w_wb_b, w_k;
    logic [5:0] w_k6;
    logic [4:0] w_tw;
    t_cplx w_cell [N];
    t_cplx w_tail, w_pair, w_x, w_y;
    logic w_wbv;
    logic signed [15:0] w_cos, w_sin;
    logic signed [15:0] w_re16, w_im16;
    logic w_sat_re, w_sat_im;

    assign o_req_ready = (r_state == S_LOAD);
    assign w_accept    = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_forward_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (w_accept) begin
            r_load_cnt <= r_load_cnt + t_addr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_load_cnt == t_addr'(N - 1)) begin
            r_fwd <= r_forward_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_load_cnt] <= {i_sample_im, i_sample_re};
        end
        r_rd <= r_mem[bit_rev(r_cnt[AW-1:0])];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_stage <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stage <= n_stage;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_stage = r_stage;
        n_pos   = r_pos;
        w_shift = 1'b0;
        w_fill  = 1'b0;
        w_take  = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (w_accept && r_load_cnt == t_addr'(N - 1)) begin
                    n_state = S_FILL;
                    n_cnt   = '0;
                end
            end
            S_FILL: begin
                w_fill  = 1'b1;
                w_shift = (r_cnt != '0);
                if (r_cnt == CW'(N)) begin
                    n_state = S_CALC;
                    n_cnt   = '0;
                    n_stage = '0;
                    n_pos   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_CALC: begin
                w_shift = 1'b1;
                n_pos   = r_pos + t_addr'(1);
                if (r_cnt == CW'(N + LAT - 1)) begin
                    n_cnt = '0;
                    if (r_stage == SW'(LOG_N - 1)) begin
                        n_state = S_ALIGN;
                    end else begin
                        n_stage = r_stage + SW'(1);
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_ALIGN: begin
                if (r_pos == '0) begin
                    n_state = S_UNLOAD;
                    n_cnt   = '0;
                end else begin
                    w_shift = 1'b1;
                    n_pos   = r_pos + t_addr'(1);
                end
            end
            S_UNLOAD: begin
                if (r_cnt == CW'(N)) begin
                    n_state = S_LOAD;
                end else if (!r_ov || i_bin_ready) begin
                    w_take  = 1'b1;
                    w_shift = 1'b1;
                    n_pos   = r_pos + t_addr'(1);
                    n_cnt   = r_cnt + CW'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        w_m = t_addr'(1) << r_stage;
        w_pair = w_cell[0];
        for (int s = 0; s < LOG_N; s++) begin
            if (r_stage == SW'(s)) begin
                w_pair = w_cell[1 << s];
            end
        end
        w_k    = r_pos & (w_m - t_addr'(1));
        w_k6   = 6'(w_k);
        w_tw   = 5'(w_k6 << (SW'(5) - r_stage));
        w_cos  = rom_cos(w_tw);
        w_sin  = r_fwd ? -rom_sin(w_tw) : rom_sin(w_tw);
        w_issue = (r_state == S_CALC) && (r_cnt < CW'(N)) && ((r_pos & w_m) == '0);
        w_wb_b = w_m - t_addr'(WB_OFS);
        w_tail.re = W'(signed'(r_rd[15:0]));
        w_tail.im = W'(signed'(r_rd[31:16]));
        if (!w_fill) begin
            w_tail = w_cell[0];
        end
    end

    r2fft_bfly u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_fwd   (r_fwd),
        .i_a     (w_cell[0]),
        .i_b     (w_pair),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_valid (w_wbv),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    for (genvar c = 0; c < N; c++) begin : g_cell
        t_cell_ctl w_ctl;
        t_cplx     w_nbr;
        logic      w_hit_a, w_hit_b;
        assign w_hit_a   = (t_addr'(c) == WB_A);
        assign w_hit_b   = (t_addr'(c) == w_wb_b);
        assign w_ctl.shift = w_shift;
        assign w_ctl.wb    = w_wbv && (w_hit_a || w_hit_b);
        if (c == N - 1) begin : g_tail
            assign w_nbr = w_tail;
        end else begin : g_body
            assign w_nbr = w_cell[c + 1];
        end
        r2fft_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_nbr    (w_nbr),
            .i_wb_val (w_hit_a ? w_x : w_y),
            .o_val    (w_cell[c])
        );
    end

    always_comb begin
        w_sat_re = 1'b0;
        w_sat_im = 1'b0;
        w_re16 = w_cell[0].re[15:0];
        w_im16 = w_cell[0].im[15:0];
        if (w_cell[0].re > W'(32767)) begin
            w_re16 = 16'sh7fff;
            w_sat_re = 1'b1;
        end else if (w_cell[0].re < -W'(32768)) begin
            w_re16 = -16'sh8000;
            w_sat_re = 1'b1;
        end
        if (w_cell[0].im > W'(32767)) begin
            w_im16 = 16'sh7fff;
            w_sat_im = 1'b1;
        end else if (w_cell[0].im < -W'(32768)) begin
            w_im16 = -16'sh8000;
            w_sat_im = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (i_bin_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ore  <= w_re16;
            r_oim  <= w_im16;
            r_last <= (r_cnt == CW'(N - 1));
            r_sat  <= w_sat_re || w_sat_im;
        end
    end

    assign o_bin_valid = r_ov;
    assign o_bin_re    = r_ore;
    assign o_bin_im    = r_oim;
    assign o_last_bin  = r_last;
    assign o_saturated = r_sat;

endmodule

// ===== src/r2fft_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the radix-2 FFT block, bound to the top level.
// Depends on the radix2_fft port list only.
module r2fft_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_bin_valid,
    input logic        i_bin_ready,
    input logic signed [15:0] o_bin_re,
    input logic signed [15:0] o_bin_im,
    input logic        o_last_bin,
    input logic        o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid && !i_bin_ready |=> o_bin_valid &&
        $stable({o_bin_re, o_bin_im, o_last_bin, o_saturated}))
        else $error("Bin changed while stalled.");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_bin_valid)
        else $error("Bin valid right after reset.");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid && o_saturated |->
        (o_bin_re == 16'sh7fff || o_bin_re == -16'sh8000 ||
         o_bin_im == 16'sh7fff || o_bin_im == -16'sh8000))
        else $error("Saturation flag without a clipped value.");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid && o_last_bin && i_bin_ready |=> !o_bin_valid)
        else $error("Bin delivered right after the last bin.");

endmodule

bind radix2_fft r2fft_chk u_r2fft_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_bin_valid (o_bin_valid),
    .i_bin_ready (i_bin_ready),
    .o_bin_re    (o_bin_re),
    .o_bin_im    (o_bin_im),
    .o_last_bin  (o_last_bin),
    .o_saturated (o_saturated)
);

// ===== bench/tb_radix2_fft.sv =====
`timescale 1ns / 1ps
// Testbench for radix2_fft: streams frames of 64 complex requests in both modes and
// checks every bin against a built-in fixed-point FFT predictor. Depends on the RTL only.
module tb_radix2_fft;

    localparam int NPTS     = 64;
    localparam int NFRAMES  = 7;
    localparam int LIMIT    = 300000;
    localparam int HOLD_LEN = 400;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
        logic               sat;
    } t_bin;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    logic signed [15:0] i_sample_re = '0;
    logic signed [15:0] i_sample_im = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;
    logic o_bin_valid;
    logic i_bin_ready = 1'b0;
    logic signed [15:0] o_bin_re;
    logic signed [15:0] o_bin_im;
    logic o_last_bin;
    logic o_saturated;

    radix2_fft dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready),
        .i_sample_re(i_sample_re), .i_sample_im(i_sample_im),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_bin_valid(o_bin_valid), .i_bin_ready(i_bin_ready),
        .o_bin_re(o_bin_re), .o_bin_im(o_bin_im),
        .o_last_bin(o_last_bin), .o_saturated(o_saturated)
    );

    const int qsin [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
        25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};

    const logic signed [15:0] dir_re [24] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
        16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0001, 16'sh0000, 16'sh7FFF,
        16'sh8000, 16'sh1234, 16'shEDCB, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh00FF,
        16'shFF00, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh8000, 16'shFFFF};
    const logic signed [15:0] dir_im [24] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
        16'sh8000, 16'sh7FFF, 16'shAAAA, 16'sh5555, 16'sh0000, 16'sh0001, 16'sh7FFF,
        16'sh8000, 16'shEDCB, 16'sh1234, 16'sh7FFF, 16'sh0000, 16'sh8000, 16'shFF00,
        16'sh00FF, 16'shC000, 16'sh4000, 16'sh8000, 16'sh7FFF, 16'shFFFF};
    const bit frame_fwd [NFRAMES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    logic signed [15:0] stored_re [NPTS];
    logic signed [15:0] stored_im [NPTS];
    int   load_cnt = 0;
    bit   fwd_mode = 1'b1;
    t_bin bins_due [$];

    int   cycles = 0;
    int   errors = 0;
    int   bins_seen = 0;
    int   sat_seen = 0;
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 59;
    bit   hold_armed = 1'b0;

    function automatic int twid_cos(int k);
        k = k & 31;
        return (k <= 16) ? qsin[16 - k] : -qsin[k - 16];
    endfunction

    function automatic int twid_sin(int k);
        k = k & 31;
        return (k <= 16) ? qsin[k] : qsin[32 - k];
    endfunction

    function automatic longint rshift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    task automatic run_transform();
        longint xr [NPTS];
        longint xi [NPTS];
        longint c, s, tr, ti, ar, ai, br, bi;
        int r, q, stride;
        t_bin b;
        bit sat;
        for (int i = 0; i < NPTS; i++) begin
            r = 0;
            for (int k = 0; k < 6; k++)
                if (i[k]) r |= 1 << (5 - k);
            xr[r] = longint'(stored_re[i]);
            xi[r] = longint'(stored_im[i]);
        end
        for (int m = 1; m < NPTS; m += m) begin
            stride = NPTS / (m + m);
            for (int k = 0; k < m; k++) begin
                c = longint'(twid_cos(k * stride));
                s = fwd_mode ? longint'(-twid_sin(k * stride))
                             : longint'(twid_sin(k * stride));
                for (int j = k; j + m < NPTS; j += m + m) begin
                    q = j + m;
                    tr = rshift(c * xr[q] - s * xi[q], 15);
                    ti = rshift(s * xr[q] + c * xi[q], 15);
                    ar = xr[j] + tr; ai = xi[j] + ti;
                    br = xr[j] - tr; bi = xi[j] - ti;
                    if (fwd_mode) begin
                        ar = rshift(ar, 1); ai = rshift(ai, 1);
                        br = rshift(br, 1); bi = rshift(bi, 1);
                    end
                    xr[j] = ar; xi[j] = ai;
                    xr[q] = br; xi[q] = bi;
                end
            end
        end
        for (int i = 0; i < NPTS; i++) begin
            sat = 1'b0;
            b.re = clip(xr[i], sat);
            b.im = clip(xi[i], sat);
            b.last = (i == NPTS - 1);
            b.sat = sat;
            bins_due.push_back(b);
        end
    endtask

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
            if (i_clk) begin
                cycles++;
                if (cycles > LIMIT) begin
                    $display("timeout at %0t", $time);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready) begin
            stored_re[load_cnt] = i_sample_re;
            stored_im[load_cnt] = i_sample_im;
            if (load_cnt == NPTS - 1) begin
                load_cnt = 0;
                run_transform();
            end else begin
                load_cnt++;
            end
        end
        if (i_rst_n && o_bin_valid && i_bin_ready) begin
            bins_seen++;
            if (o_saturated) sat_seen++;
            if (bins_due.size() == 0) begin
                $display("%0t: bin with none expected: re %0d im %0d", $time,
                    o_bin_re, o_bin_im);
                errors++;
            end else begin
                t_bin e;
                e = bins_due.pop_front();
                if (e.re !== o_bin_re || e.im !== o_bin_im || e.last !== o_last_bin
                        || e.sat !== o_saturated) begin
                    $display("%0t: expected re %0d im %0d last %0b sat %0b", $time,
                        e.re, e.im, e.last, e.sat);
                    $display("%0t: actual   re %0d im %0d last %0b sat %0b", $time,
                        o_bin_re, o_bin_im, o_last_bin, o_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && o_bin_valid && hold == 0) begin
                hold = HOLD_LEN;
                hold_armed = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_bin_ready = 1'b0;
            end else begin
                i_bin_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_req(logic signed [15:0] re, logic signed [15:0] im);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_req_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_req_valid = 1'b1;
        i_sample_re = re;
        i_sample_im = im;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
        i_req_valid = 1'b0;
    endtask

    task automatic write_mode(bit fwd);
        wait (bins_due.size() == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = fwd;
        fwd_mode = fwd;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic signed [15:0] re, im;
        int first;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        for (int f = 0; f < NFRAMES; f++) begin
            if (f < 3) begin
                tx_idle_pct = 10; rx_idle_pct = 59;
            end else if (f < 5) begin
                tx_idle_pct = 59; rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            // Frames three and four follow without a pause so the held-off
            // receiver backs the block up into the request side.
            if (f == 3) hold_armed = 1'b1;
            if (f != 3 && f != 4 && (f != 0 || frame_fwd[f] != fwd_mode))
                write_mode(frame_fwd[f]);
            first = 0;
            if (f == 0) begin
                for (int i = 0; i < 24; i++) send_req(dir_re[i], dir_im[i]);
                first = 24;
            end
            for (int i = first; i < NPTS; i++) begin
                re = 16'($urandom);
                im = 16'($urandom);
                if ($urandom_range(1)) begin
                    re = re >>> 5;
                    im = im >>> 5;
                end
                send_req(re, im);
            end
        end
        i_req_valid = 1'b0;
        wait (bins_due.size() == 0);
        repeat (50) @(negedge i_clk);
        $display("Ran %0d frames in both directions, %0d bins checked, %0d saturated.",
            NFRAMES, bins_seen, sat_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
